[src/quoted_scalar_escaper_defines.svh]
// ----------------------------------------------------------------------------
// Quoted scalar escaper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_SCALAR_ESCAPER_DEFINES_SVH
`define QUOTED_SCALAR_ESCAPER_DEFINES_SVH

// Same-cycle implication.
`define QSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/qse_pkg.sv]
// ----------------------------------------------------------------------------
// Quoted scalar escaper package
// Types, character constants and helpers shared by the escaper modules.
// ----------------------------------------------------------------------------
package qse_pkg;

	typedef logic [20:0] cp_t;
	typedef logic [3:0]  len_t;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_PAIR,
		KIND_HEX2,
		KIND_HEX8,
		KIND_EMPTY
	} kind_t;

	// One classified input item, waiting to be expanded into output characters.
	typedef struct packed {
		kind_t kind;
		cp_t   cp;     // the character, or the escape letter for a two-character escape
		logic  first;
		logic  last;
		len_t  len;    // number of outputs this item produces
	} desc_t;

	localparam int unsigned FifoDepth = 2;

	localparam cp_t CH_QUOTE  = 21'h22;
	localparam cp_t CH_BSLASH = 21'h5c;
	localparam cp_t CH_TAB    = 21'h09;
	localparam cp_t CH_NL     = 21'h0a;
	localparam cp_t CH_N      = 21'h6e;
	localparam cp_t CH_T      = 21'h74;
	localparam cp_t CH_X      = 21'h78;
	localparam cp_t CH_U      = 21'h55;
	localparam cp_t CH_ZERO   = 21'h30;
	localparam cp_t CH_SPACE  = 21'h20;
	localparam cp_t CH_DEL    = 21'h7f;
	localparam cp_t CH_C1_END = 21'h9f;
	localparam cp_t CH_LSEP   = 21'h2028;
	localparam cp_t CH_PSEP   = 21'h2029;
	localparam cp_t CH_NONCH  = 21'hfffe;
	// Offset that maps nibble values 10..15 onto 'a'..'f'.
	localparam cp_t CH_ALPHA_OFS = 21'h57;

	localparam len_t LEN_PLAIN = 4'd1;
	localparam len_t LEN_PAIR  = 4'd2;
	localparam len_t LEN_HEX2  = 4'd4;
	localparam len_t LEN_HEX8  = 4'd10;

	function automatic cp_t hex_char(input logic [3:0] nib);
		cp_t r;
		if (nib < 4'd10) begin
			r = CH_ZERO + cp_t'(nib);
		end else begin
			r = CH_ALPHA_OFS + cp_t'(nib);
		end
		return r;
	endfunction

endpackage

[src/qse_front.sv]
// ----------------------------------------------------------------------------
// Quoted scalar escaper front end
// Accepts input items and classifies each into an escape kind and length.
// ----------------------------------------------------------------------------
module qse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qse_pkg::cp_t     code_point,
	input  logic             first_char,
	input  logic             last_char,
	input  logic             empty_marker,
	output logic             desc_valid,
	input  logic             desc_ready,
	output qse_pkg::desc_t   desc
);

	logic           valid_s1;
	qse_pkg::desc_t desc_s1;
	qse_pkg::desc_t cls;
	qse_pkg::len_t  body_len;
	logic           take;

	assign in_ready   = !valid_s1 || desc_ready;
	assign take       = in_valid && in_ready;
	assign desc_valid = valid_s1;
	assign desc       = desc_s1;

	always_comb begin
		cls.cp    = code_point;
		cls.first = first_char;
		cls.last  = last_char;
		cls.kind  = qse_pkg::KIND_PLAIN;
		body_len  = qse_pkg::LEN_PLAIN;
		if (empty_marker) begin
			cls.kind  = qse_pkg::KIND_EMPTY;
			cls.first = 1'b0;
			cls.last  = 1'b0;
			body_len  = qse_pkg::LEN_PAIR;
		end else if (code_point == qse_pkg::CH_BSLASH || code_point == qse_pkg::CH_QUOTE) begin
			cls.kind = qse_pkg::KIND_PAIR;
			body_len = qse_pkg::LEN_PAIR;
		end else if (code_point == qse_pkg::CH_NL) begin
			cls.kind = qse_pkg::KIND_PAIR;
			cls.cp   = qse_pkg::CH_N;
			body_len = qse_pkg::LEN_PAIR;
		end else if (code_point == qse_pkg::CH_TAB) begin
			cls.kind = qse_pkg::KIND_PAIR;
			cls.cp   = qse_pkg::CH_T;
			body_len = qse_pkg::LEN_PAIR;
		end else if (code_point < qse_pkg::CH_SPACE ||
				(code_point >= qse_pkg::CH_DEL && code_point <= qse_pkg::CH_C1_END)) begin
			cls.kind = qse_pkg::KIND_HEX2;
			body_len = qse_pkg::LEN_HEX2;
		end else if (code_point == qse_pkg::CH_LSEP || code_point == qse_pkg::CH_PSEP ||
				code_point >= qse_pkg::CH_NONCH) begin
			cls.kind = qse_pkg::KIND_HEX8;
			body_len = qse_pkg::LEN_HEX8;
		end
		cls.len = body_len + qse_pkg::len_t'(cls.first) + qse_pkg::len_t'(cls.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_s1 <= cls;
		end
	end

endmodule

[src/qse_fifo.sv]
// ----------------------------------------------------------------------------
// Quoted scalar escaper item queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`include "quoted_scalar_escaper_defines.svh"

module qse_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  qse_pkg::desc_t push_desc,
	output logic           head_valid,
	output qse_pkg::desc_t head,
	input  logic           pop
);

	localparam int unsigned PtrW = (qse_pkg::FifoDepth > 1) ? $clog2(qse_pkg::FifoDepth) : 1;
	localparam int unsigned CntW = $clog2(qse_pkg::FifoDepth + 1);
	localparam logic [CntW-1:0] Full = CntW'(qse_pkg::FifoDepth);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(qse_pkg::FifoDepth - 1);

	qse_pkg::desc_t      mem_q [qse_pkg::FifoDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                wr_en;
	logic                rd_en;

	assign push_ready = (count_q != Full);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign wr_en      = push && push_ready;
	assign rd_en      = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	`QSE_ASSERT_IMP(a_count_range, 1'b1, count_q <= Full, "queue count above depth")
	`QSE_ASSERT_IMP(a_pop_nonempty, pop, count_q != '0, "pop from empty queue")

endmodule

[src/qse_back.sv]
// ----------------------------------------------------------------------------
// Quoted scalar escaper back end
// Expands the queue head into output characters, one per cycle unless held.
// ----------------------------------------------------------------------------
`include "quoted_scalar_escaper_defines.svh"

module qse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  qse_pkg::desc_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output qse_pkg::cp_t   out_char,
	output logic           out_last
);

	qse_pkg::len_t pos_q;
	logic          out_valid_q;
	qse_pkg::cp_t  out_char_q;
	logic          out_last_q;

	logic          load;
	logic          fire;
	logic          at_end;
	qse_pkg::len_t body_idx;
	logic [2:0]    nib_idx;
	logic [31:0]   wide_cp;
	logic [3:0]    nib8;
	qse_pkg::cp_t  ch;

	assign load     = !out_valid_q || out_ready;
	assign fire     = head_valid && load;
	assign at_end   = (pos_q == head.len - 1'b1);
	assign pop      = fire && at_end;
	assign body_idx = pos_q - qse_pkg::len_t'(head.first);
	// Digits of the long escape run from the top nibble at body position two.
	assign nib_idx  = 3'(4'd9 - body_idx);
	assign wide_cp  = {11'b0, head.cp};
	assign nib8     = wide_cp[nib_idx*4 +: 4];

	always_comb begin
		ch = qse_pkg::CH_QUOTE;
		if (head.first && pos_q == '0) begin
			ch = qse_pkg::CH_QUOTE;
		end else if (head.last && at_end) begin
			ch = qse_pkg::CH_QUOTE;
		end else begin
			unique case (head.kind)
				qse_pkg::KIND_PLAIN: ch = head.cp;
				qse_pkg::KIND_PAIR:  ch = (body_idx == '0) ? qse_pkg::CH_BSLASH : head.cp;
				qse_pkg::KIND_HEX2: begin
					case (body_idx)
						4'd0:    ch = qse_pkg::CH_BSLASH;
						4'd1:    ch = qse_pkg::CH_X;
						4'd2:    ch = qse_pkg::hex_char(head.cp[7:4]);
						default: ch = qse_pkg::hex_char(head.cp[3:0]);
					endcase
				end
				qse_pkg::KIND_HEX8: begin
					case (body_idx)
						4'd0:    ch = qse_pkg::CH_BSLASH;
						4'd1:    ch = qse_pkg::CH_U;
						default: ch = qse_pkg::hex_char(nib8);
					endcase
				end
				qse_pkg::KIND_EMPTY: ch = qse_pkg::CH_QUOTE;
				default:             ch = head.cp;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (fire) begin
				pos_q <= at_end ? '0 : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char_q <= ch;
			out_last_q <= at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	`QSE_ASSERT_IMP(a_pos_in_run, head_valid, pos_q < head.len, "run position past item length")
	`QSE_ASSERT_NXT(a_pop_marks_last, pop, out_valid && out_last, "item retired without last output")

endmodule

[src/quoted_scalar_escaper.sv]
// ----------------------------------------------------------------------------
// Quoted scalar escaper
// Turns a stream of string code points into double-quoted, escaped text.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one code point per transfer in s_axis_tdata, the
// first-character mark and the empty-string marker in s_axis_tuser, and the
// last-character mark in s_axis_tlast. The master stream carries one output
// code point per transfer, with m_axis_tlast set on the final output that an
// input item produces.
// Each item yields 1 to 12 outputs. The back end emits one output per cycle
// while the receiver is ready, so the sustained rate is one item per cycle
// for plain characters without quote marks; an escape holds the back end
// until all its outputs are emitted, while the front end and a two-entry
// queue keep taking items until the queue fills. The first output of an item
// passes through the front stage register, the queue and the output register.
// Reset empties the stage register, the queue and the output register, and
// clears the back end's run position. When the receiver holds m_axis_tready
// low the output register holds its transfer, the back end stops and input
// stalls once the queue and front stage are full.
// ----------------------------------------------------------------------------
module quoted_scalar_escaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
	input  logic [1:0]  s_axis_tuser,   // [0] first_char, [1] empty_marker
	input  logic        s_axis_tlast,   // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] out_char, [23:21] zero
	output logic        m_axis_tlast    // last_of_run
);

	logic           push;
	logic           push_ready;
	qse_pkg::desc_t push_desc;
	logic           head_valid;
	qse_pkg::desc_t head;
	logic           pop;
	qse_pkg::cp_t   out_char;

	qse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.code_point   (s_axis_tdata[20:0]),
		.first_char   (s_axis_tuser[0]),
		.last_char    (s_axis_tlast),
		.empty_marker (s_axis_tuser[1]),
		.desc_valid   (push),
		.desc_ready   (push_ready),
		.desc         (push_desc)
	);

	qse_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	qse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (out_char),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_char};

endmodule
